// ===== rtl/core/grid_alternating_move_bfs_defines.svh =====
// assertion macros for the grid search block
`ifndef GRID_ALTERNATING_MOVE_BFS_DEFINES_SVH
`define GRID_ALTERNATING_MOVE_BFS_DEFINES_SVH
`define GAMB_ASSERT_IMP(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`define GAMB_ASSERT_NXT(lbl, clk, rstn, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/gamb_pkg.sv =====
// package for the grid search block
`default_nettype none
package gamb_pkg;
    localparam int unsigned DefMaxRows = 64;
    localparam int unsigned DefMaxCols = 64;
    localparam int unsigned StepW = 13;
    localparam logic [StepW-1:0] StepMax = 13'h1fff;
    localparam logic [1:0] CodeFree = 2'd0;
    localparam logic [1:0] CodeWall = 2'd1;
    localparam logic [1:0] CodeStart = 2'd2;
    localparam logic [1:0] CodeGoal = 2'd3;
    localparam logic [0:0] RegRows = 1'b0;
    localparam logic [0:0] RegCols = 1'b1;
    typedef enum logic [2:0] {
        t_idle, t_clear, t_seed, t_pop, t_load, t_wait, t_expand, t_done
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/core/gamb_front.sv =====
// cell loader: writes cells row-major and raises a search request at the end of a grid
`default_nettype none
module gamb_front import gamb_pkg::*; #(
    parameter int unsigned RW = 6,
    parameter int unsigned CW = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire logic          i_restart,
    input  wire logic [RW:0]   i_rows,
    input  wire logic [CW:0]   i_cols,
    output      logic          o_we,
    output      logic [RW-1:0] o_wr,
    output      logic [CW-1:0] o_wc,
    output      logic          o_last
);
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic endc, endr;
    assign endc = ({1'b0, r_col} + 1'b1) >= i_cols;
    assign endr = ({1'b0, r_row} + 1'b1) >= i_rows;
    assign o_we = i_take;
    assign o_wr = r_row;
    assign o_wc = r_col;
    assign o_last = i_take && endc && endr;
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_restart) begin
            n_row = '0;
            n_col = '0;
        end else if (i_take) begin
            if (endc) begin
                n_col = '0;
                n_row = endr ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/gamb_back.sv =====
// search engine: cell memory, visited map, state queue and sequencer
`default_nettype none
module gamb_back import gamb_pkg::*; #(
    parameter int unsigned RW = 6,
    parameter int unsigned CW = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_we,
    input  wire logic [RW-1:0]    i_wr,
    input  wire logic [CW-1:0]    i_wc,
    input  wire logic [1:0]       i_code,
    input  wire logic             i_go,
    input  wire logic [RW:0]      i_rows,
    input  wire logic [CW:0]      i_cols,
    output      logic             o_busy,
    output      logic             o_done,
    output      logic             o_found,
    output      logic [StepW-1:0] o_steps
);
    localparam int unsigned AW = RW + CW;
    localparam int unsigned SW = AW + 1;
    localparam int unsigned QW = SW + StepW;
    localparam int unsigned Cells = 1 << AW;
    localparam int unsigned States = 1 << SW;

    logic [1:0] cells [Cells];
    logic       vis [States];
    logic [QW-1:0] que [States];

    t_state r_st, n_st;
    logic [SW-1:0] r_ptr, n_ptr;
    logic [SW:0] r_head, n_head, r_tail, n_tail;
    logic [SW-1:0] r_cur, n_cur;
    logic [StepW-1:0] r_dist, n_dist;
    logic r_k, n_k;
    logic r_found, n_found;
    logic [StepW-1:0] r_steps, n_steps;

    logic [1:0] cur_code, nb_code;
    logic       nb_vis;
    logic [QW-1:0] q_rd;
    logic [AW-1:0] rd_a, nb_a;
    logic [SW-1:0] vis_ra, vis_wa;
    logic vis_we, vis_wd, q_we;
    logic [QW-1:0] q_wd;

    logic cph;
    logic [RW-1:0] cr, nr;
    logic [CW-1:0] cc, nc;
    logic nb_ok;
    logic [SW-1:0] nb_state;

    assign cph = r_cur[SW-1];
    assign cr = r_cur[AW-1:CW];
    assign cc = r_cur[CW-1:0];

    always_comb begin
        nr = cr;
        nc = cc;
        nb_ok = 1'b0;
        if (cph) begin
            if (!r_k) begin
                nc = cc - 1'b1;
                nb_ok = cc != '0;
            end else begin
                nc = cc + 1'b1;
                nb_ok = ({1'b0, cc} + 1'b1) < i_cols;
            end
        end else begin
            if (!r_k) begin
                nr = cr - 1'b1;
                nb_ok = cr != '0;
            end else begin
                nr = cr + 1'b1;
                nb_ok = ({1'b0, cr} + 1'b1) < i_rows;
            end
        end
    end
    assign nb_a = {nr, nc};
    assign nb_state = {~cph, nr, nc};

    // registered reads of the memories
    always_comb begin
        rd_a = r_ptr[AW-1:0];
        vis_ra = r_ptr;
        if (r_st == t_expand || r_st == t_wait) begin
            rd_a = nb_a;
            vis_ra = nb_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) cells[{i_wr, i_wc}] <= i_code;
        cur_code <= cells[r_cur[AW-1:0]];
        nb_code <= cells[rd_a];
    end
    always_ff @(posedge i_clk) begin
        if (vis_we) vis[vis_wa] <= vis_wd;
        nb_vis <= vis[vis_ra];
    end
    always_ff @(posedge i_clk) begin
        if (q_we) que[r_tail[SW-1:0]] <= q_wd;
        q_rd <= que[r_head[SW-1:0]];
    end

    logic seed_row_ok, seed_col_ok;
    assign seed_row_ok = {1'b0, r_ptr[AW-1:CW]} < i_rows;
    assign seed_col_ok = {1'b0, r_ptr[CW-1:0]} < i_cols;

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            t_idle:   if (i_go) n_st = t_clear;
            t_clear:  if (&r_ptr) n_st = t_seed;
            t_seed:   if (r_k && &r_ptr) n_st = t_pop;
            t_pop:    n_st = (r_head == r_tail) ? t_done : t_load;
            t_load:   n_st = t_wait;
            t_wait:   n_st = t_expand;
            t_expand: begin
                if (cur_code == CodeGoal) n_st = t_done;
                else if (r_k) n_st = t_pop;
                else n_st = t_wait;
            end
            t_done:   n_st = t_idle;
            default:  n_st = t_idle;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_ptr = r_ptr;
        n_head = r_head;
        n_tail = r_tail;
        n_cur = r_cur;
        n_dist = r_dist;
        n_k = r_k;
        n_found = r_found;
        n_steps = r_steps;
        vis_we = 1'b0;
        vis_wa = r_ptr;
        vis_wd = 1'b0;
        q_we = 1'b0;
        q_wd = '0;
        unique case (r_st)
            t_idle: begin
                n_ptr = '0;
                n_k = 1'b0;
            end
            t_clear: begin
                vis_we = 1'b1;
                n_ptr = r_ptr + 1'b1;
                n_head = '0;
                n_tail = '0;
                n_k = 1'b0;
            end
            t_seed: begin
                // pass 0 reads, pass 1 pushes from the registered read, both phases
                n_k = ~r_k;
                if (r_k) n_ptr = r_ptr + 1'b1;
                if (r_k && nb_code == CodeStart && seed_row_ok && seed_col_ok) begin
                    vis_we = 1'b1;
                    vis_wd = 1'b1;
                    q_we = 1'b1;
                    q_wd = {r_ptr, {StepW{1'b0}}};
                end
            end
            t_pop: begin
                n_k = 1'b0;
            end
            t_load: begin
                n_cur = q_rd[QW-1:StepW];
                n_dist = q_rd[StepW-1:0];
                n_head = r_head + 1'b1;
                n_k = 1'b0;
            end
            t_wait: ;
            t_expand: begin
                if (cur_code == CodeGoal) begin
                    n_found = 1'b1;
                    n_steps = r_dist;
                end else begin
                    if (nb_ok && nb_code != CodeWall && !nb_vis) begin
                        vis_we = 1'b1;
                        vis_wa = nb_state;
                        vis_wd = 1'b1;
                        q_we = 1'b1;
                        q_wd = {nb_state, (&r_dist) ? r_dist : r_dist + 1'b1};
                    end
                    n_k = ~r_k;
                end
            end
            t_done: ;
            default: ;
        endcase
        if (q_we) n_tail = r_tail + 1'b1;
    end

    assign o_busy = r_st != t_idle;
    assign o_done = r_st == t_done;
    assign o_found = r_found;
    assign o_steps = r_found ? r_steps : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= t_idle;
            r_ptr <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_k <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ptr <= n_ptr;
            r_head <= n_head;
            r_tail <= n_tail;
            r_k <= n_k;
            r_found <= (r_st == t_idle) ? 1'b0 : n_found;
        end
        r_cur <= n_cur;
        r_dist <= n_dist;
        r_steps <= n_steps;
    end
endmodule
`default_nettype wire

// ===== rtl/core/grid_alternating_move_bfs.sv =====
// top level of the alternating-move grid search
// sequence: a cell is stored while start is high and busy is low; the last cell starts
// a search that clears the visited map, scans every cell in both phases for starts,
// then takes each queued state through pop, load, and a wait and expand step per move
// throughput: one cell per cycle while not busy, busy high until the result word cycle ends
// reset: synchronous active low, sizes return to 64, loading restarts at cell 0
`default_nettype none
`include "grid_alternating_move_bfs_defines.svh"
module grid_alternating_move_bfs import gamb_pkg::*; #(
    parameter int unsigned MAX_ROWS = DefMaxRows,
    parameter int unsigned MAX_COLS = DefMaxCols
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output      logic             busy,
    input  wire logic [1:0]       i_cell_code,
    output      logic             o_valid,
    output      logic             o_path_found,
    output      logic [StepW-1:0] o_step_count,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output      logic [31:0]      prdata,
    output      logic             pready
);
    localparam int unsigned RW = $clog2(MAX_ROWS);
    localparam int unsigned CW = $clog2(MAX_COLS);

    logic [6:0] r_rows, r_cols;
    logic [RW:0] rows_e;
    logic [CW:0] cols_e;
    logic wr, take, restart;
    logic we, last, bbusy, done, found;
    logic [RW-1:0] wrow;
    logic [CW-1:0] wcol;
    logic [StepW-1:0] steps;

    always_comb begin
        if (r_rows == '0) rows_e = (RW+1)'(1);
        else if ({25'd0, r_rows} > 32'(MAX_ROWS)) rows_e = (RW+1)'(MAX_ROWS);
        else rows_e = (RW+1)'(r_rows);
        if (r_cols == '0) cols_e = (CW+1)'(1);
        else if ({25'd0, r_cols} > 32'(MAX_COLS)) cols_e = (CW+1)'(MAX_COLS);
        else cols_e = (CW+1)'(r_cols);
    end

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign restart = wr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 7'd64;
            r_cols <= 7'd64;
        end else if (restart) begin
            unique case (paddr[2])
                RegRows: r_rows <= pwdata[6:0];
                RegCols: r_cols <= pwdata[6:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr == 3'd0) prdata = {25'd0, r_rows};
        else if (paddr == 3'd4) prdata = {25'd0, r_cols};
    end

    assign busy = bbusy;
    assign take = start && !bbusy;

    gamb_front #(.RW(RW), .CW(CW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take), .i_restart(restart),
        .i_rows(rows_e), .i_cols(cols_e), .o_we(we), .o_wr(wrow), .o_wc(wcol),
        .o_last(last)
    );

    gamb_back #(.RW(RW), .CW(CW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_we(we), .i_wr(wrow), .i_wc(wcol),
        .i_code(i_cell_code), .i_go(last), .i_rows(rows_e), .i_cols(cols_e),
        .o_busy(bbusy), .o_done(done), .o_found(found), .o_steps(steps)
    );

    assign o_valid = done;
    assign o_path_found = found;
    assign o_step_count = steps;

    `GAMB_ASSERT_NXT(a_go_busy, i_clk, i_rst_n, last, busy)
    `GAMB_ASSERT_IMP(a_zero_steps, i_clk, i_rst_n, o_valid && !o_path_found, o_step_count == '0)
endmodule
`default_nettype wire
